>>> rtl/vpd_kfe_pkg.sv
// Shared types, constants and codes for the VPD keyword field extractor.
package vpd_kfe_pkg;

   // Image and field layout
   localparam int unsigned IMAGE_BYTES_DEFAULT = 256;
   localparam int unsigned HDR_LEN_HIGH_POS    = 4;
   localparam int unsigned HDR_LEN_LOW_POS     = 5;
   localparam int unsigned BODY_START          = 8;
   localparam int unsigned DATA_OFFSET         = 4;
   localparam logic [7:0]  FIELD_DELIM         = 8'h2A;

   // Field length and body length widths
   localparam int unsigned FLEN_W = 9;
   localparam int unsigned BODY_W = 17;

   // Result queue
   localparam int unsigned RSP_QUEUE_DEPTH = 4;

   // Register map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [7:0]  KEYWORD_FIRST_RESET  = 8'd68;
   localparam logic [7:0]  KEYWORD_SECOND_RESET = 8'd83;

   typedef enum logic {
      REG_KEYWORD_FIRST  = 1'b0,
      REG_KEYWORD_SECOND = 1'b1
   } vpd_reg_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_FOUND = 2'd1,
      KIND_FAIL  = 2'd2
   } vpd_kind_type;

   // Parser phases
   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_FIELD  = 5'b00010,
      PH_SKIP   = 5'b00100,
      PH_DATA   = 5'b01000,
      PH_DONE   = 5'b10000
   } vpd_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } vpd_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       run_end;
   } vpd_rsp_type;

endpackage

>>> rtl/vpd_kfe_rsp_queue.sv
// Result queue: takes up to two result beats per cycle, delivers one per cycle when popped.
module vpd_kfe_rsp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               push_cnt,
   input  vpd_kfe_pkg::vpd_rsp_type push0,
   input  vpd_kfe_pkg::vpd_rsp_type push1,
   input  logic                     pop,
   output vpd_kfe_pkg::vpd_rsp_type head,
   output logic                     not_empty,
   output logic                     almost_full
);
   import vpd_kfe_pkg::*;

   localparam int unsigned PTR_W = $clog2(RSP_QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(RSP_QUEUE_DEPTH + 1);

   vpd_rsp_type             entry_ff [RSP_QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [PTR_W-1:0]        wr_next;

   assign wr_next     = wr_ptr_ff + PTR_W'(1);
   assign head        = entry_ff[rd_ptr_ff];
   assign not_empty   = (count_ff != '0);
   // Leave room for a two-beat item
   assign almost_full = (count_ff > CNT_W'(RSP_QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         entry_ff[wr_next] <= push1;
      end
   end

endmodule

>>> rtl/vpd_keyword_field_extractor.sv
// Results: an accepted byte's results are queued at the accepting edge and show
// on rsp in the following cycle at the earliest. Throughput: one image byte per
// cycle unless req_stall; a byte yields up to two result beats, drained one per
// cycle unless rsp_stall from a four-entry result queue that stalls req above two.
// Reset: synchronous; parser returns to the header phase, the queue empties and
// the keyword registers return to 'D' and 'S'.
module vpd_keyword_field_extractor #(
   parameter int unsigned IMAGE_BYTES = vpd_kfe_pkg::IMAGE_BYTES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  vpd_kfe_pkg::vpd_req_type               req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output vpd_kfe_pkg::vpd_rsp_type               rsp_data,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [vpd_kfe_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [vpd_kfe_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [vpd_kfe_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                   pready
);
   import vpd_kfe_pkg::*;

   localparam int unsigned POS_W = $clog2(IMAGE_BYTES);

   // Keyword registers
   logic [7:0] kw_first_ff, kw_second_ff;
   logic       csr_wr;
   vpd_reg_type csr_sel;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_sel = vpd_reg_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         kw_first_ff  <= KEYWORD_FIRST_RESET;
         kw_second_ff <= KEYWORD_SECOND_RESET;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_KEYWORD_FIRST:  kw_first_ff  <= pwdata[7:0];
            REG_KEYWORD_SECOND: kw_second_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_KEYWORD_FIRST:  prdata = {{(CSR_DATA_W-8){1'b0}}, kw_first_ff};
         REG_KEYWORD_SECOND: prdata = {{(CSR_DATA_W-8){1'b0}}, kw_second_ff};
         default:            prdata = '0;
      endcase
   end

   // Parser state
   vpd_phase_type     phase_ff, phase_in, phase_eff;
   logic [POS_W-1:0]  pos_ff, pos_in, pos_eff;
   logic [BODY_W-1:0] body_ff, body_in;
   logic [7:0]        len_hi_ff, len_hi_in;
   logic [FLEN_W-1:0] flen_ff, flen_in;
   logic [FLEN_W-1:0] off_ff, off_in;
   logic [1:0]        km_ff, km_in;

   logic              accept;
   logic [7:0]        b;
   logic              has_data, has_end;
   vpd_kind_type      end_kind;
   logic [FLEN_W-1:0] new_flen;
   logic [BODY_W-1:0] new_flen_ext;
   logic              off_last;
   logic [1:0]        push_cnt;
   vpd_rsp_type       res_data, res_end, push0, push1;
   logic              queue_almost_full;

   assign accept    = req_valid && !req_stall;
   assign b         = req_data.data_byte;
   assign phase_eff = req_data.first_byte ? PH_HEADER : phase_ff;
   assign pos_eff   = req_data.first_byte ? '0 : pos_ff;
   assign new_flen  = {b, 1'b0};
   assign new_flen_ext = BODY_W'(new_flen);
   assign off_last  = ({1'b0, off_ff} + (FLEN_W+1)'(1)) >= {1'b0, flen_ff};

   always_comb begin
      phase_in  = phase_eff;
      pos_in    = pos_eff;
      body_in   = body_ff;
      len_hi_in = len_hi_ff;
      flen_in   = flen_ff;
      off_in    = off_ff;
      km_in     = km_ff;
      has_data  = 1'b0;
      has_end   = 1'b0;
      end_kind  = KIND_FAIL;

      unique case (phase_eff)
         PH_HEADER: begin
            if (pos_eff == POS_W'(HDR_LEN_HIGH_POS)) begin
               len_hi_in = b;
            end
            if (pos_eff == POS_W'(HDR_LEN_LOW_POS)) begin
               body_in = {len_hi_ff, b, 1'b0};
            end
            if (pos_eff == POS_W'(BODY_START - 1)) begin
               phase_in = PH_FIELD;
               off_in   = '0;
            end
         end
         PH_FIELD: begin
            if (off_ff == FLEN_W'(0)) begin
               if (body_ff == '0 || b != FIELD_DELIM) begin
                  has_end = 1'b1;
               end else begin
                  km_in  = 2'b00;
                  off_in = FLEN_W'(1);
               end
            end else if (off_ff == FLEN_W'(1)) begin
               km_in[0] = km_ff[0] | (b == kw_first_ff);
               off_in   = FLEN_W'(2);
            end else if (off_ff == FLEN_W'(2)) begin
               km_in[1] = km_ff[1] | (b == kw_second_ff);
               off_in   = FLEN_W'(3);
            end else begin
               flen_in = new_flen;
               if (b < 8'd2) begin
                  // Zero or one word field: malformed
                  has_end = 1'b1;
               end else if (km_ff == 2'b11) begin
                  if (new_flen == FLEN_W'(DATA_OFFSET)) begin
                     has_end  = 1'b1;
                     end_kind = KIND_FOUND;
                  end else begin
                     phase_in = PH_DATA;
                     off_in   = FLEN_W'(DATA_OFFSET);
                  end
               end else begin
                  // Saturate what remains of the body
                  body_in = (body_ff > new_flen_ext) ? body_ff - new_flen_ext : '0;
                  if (new_flen == FLEN_W'(DATA_OFFSET)) begin
                     off_in = '0;
                  end else begin
                     phase_in = PH_SKIP;
                     off_in   = FLEN_W'(DATA_OFFSET);
                  end
               end
            end
         end
         PH_SKIP: begin
            if (off_last) begin
               phase_in = PH_FIELD;
               off_in   = '0;
            end else begin
               off_in = off_ff + FLEN_W'(1);
            end
         end
         PH_DATA: begin
            if (b == 8'd0) begin
               has_end  = 1'b1;
               end_kind = KIND_FOUND;
            end else begin
               has_data = 1'b1;
               if (off_last) begin
                  has_end  = 1'b1;
                  end_kind = KIND_FOUND;
               end else begin
                  off_in = off_ff + FLEN_W'(1);
               end
            end
         end
         PH_DONE: ;
         default: ;
      endcase

      if (phase_eff != PH_DONE) begin
         if (!has_end && (req_data.last_byte || pos_eff == POS_W'(IMAGE_BYTES - 1))) begin
            has_end  = 1'b1;
            end_kind = KIND_FAIL;
         end
         if (has_end) begin
            phase_in = PH_DONE;
         end else begin
            pos_in = pos_eff + POS_W'(1);
         end
      end
   end

   always_comb begin
      res_data.out_byte = b;
      res_data.kind     = KIND_DATA;
      res_data.run_end  = 1'b0;
      res_end.out_byte  = 8'd0;
      res_end.kind      = end_kind;
      res_end.run_end   = 1'b1;
      push0    = has_data ? res_data : res_end;
      push1    = res_end;
      push_cnt = accept ? (2'(has_data) + 2'(has_end)) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         body_ff   <= body_in;
         len_hi_ff <= len_hi_in;
         flen_ff   <= flen_in;
         off_ff    <= off_in;
         km_ff     <= km_in;
      end
   end

   vpd_kfe_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push_cnt    (push_cnt),
      .push0       (push0),
      .push1       (push1),
      .pop         (rsp_valid && !rsp_stall),
      .head        (rsp_data),
      .not_empty   (rsp_valid),
      .almost_full (queue_almost_full)
   );

   assign req_stall = queue_almost_full;

endmodule

>>> rtl/vpd_kfe_checker.sv
// Port-level checks for the VPD keyword field extractor, bound to the top level.
module vpd_kfe_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input vpd_kfe_pkg::vpd_rsp_type rsp_data
);
   import vpd_kfe_pkg::*;

   // Queue is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // Data beats never end a run; end beats carry a zero byte
   a_rsp_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.kind == KIND_DATA && !rsp_data.run_end) ||
         ((rsp_data.kind == KIND_FOUND || rsp_data.kind == KIND_FAIL) &&
          rsp_data.run_end && rsp_data.out_byte == 8'd0))
      else $error("malformed result beat");

   // Input only stalls while results are waiting
   a_stall_has_backlog: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

bind vpd_keyword_field_extractor vpd_kfe_checker u_vpd_kfe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> test/tb_vpd_keyword_field_extractor.sv
// Testbench for the VPD keyword field extractor: byte-level predictor and result checks.
`timescale 1ns / 1ps

module tb_vpd_keyword_field_extractor;
   import vpd_kfe_pkg::*;

   localparam int unsigned IMAGE_LIMIT     = IMAGE_BYTES_DEFAULT;
   localparam int          QUIET_LIMIT     = 2000;
   localparam int          HOLD_CYCLES     = 150;
   localparam int          SETTLE_CYCLES   = 8;
   localparam int          PHASE_COUNT     = 6;
   localparam int          BYTES_PER_PHASE = 150;

   // Tracks the parse of the image stream and the result beats it must produce.
   class field_extract_checker;
      logic [7:0]    kw_first;
      logic [7:0]    kw_second;
      vpd_phase_type phase;
      int unsigned   byte_pos;
      int unsigned   body_left;
      int unsigned   field_len;
      int unsigned   field_off;
      logic [7:0]    len_high;
      logic [1:0]    kw_hits;
      bit            finished;
      vpd_rsp_type   expected_beats[$];
      int            mismatches;

      function new();
         kw_first   = KEYWORD_FIRST_RESET;
         kw_second  = KEYWORD_SECOND_RESET;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         phase     = PH_HEADER;
         byte_pos  = 0;
         body_left = 0;
         len_high  = '0;
         field_len = 0;
         field_off = 0;
         kw_hits   = '0;
         finished  = 1'b0;
      endfunction

      function void set_keyword(vpd_reg_type idx, logic [7:0] value);
         if (idx == REG_KEYWORD_FIRST) kw_first = value;
         else kw_second = value;
      endfunction

      function void emit(logic [7:0] value, vpd_kind_type kind, bit run_end);
         vpd_rsp_type beat;
         beat.out_byte = value;
         beat.kind     = kind;
         beat.run_end  = run_end;
         expected_beats.push_back(beat);
         if (run_end) finished = 1'b1;
      endfunction

      function void take_byte(vpd_req_type item);
         logic [7:0] b;
         b = item.data_byte;
         if (item.first_byte) restart();
         if (finished) return;
         case (phase)
            PH_HEADER: begin
               if (byte_pos == HDR_LEN_HIGH_POS) len_high = b;
               else if (byte_pos == HDR_LEN_LOW_POS) body_left = 2 * int'({len_high, b});
               if (byte_pos == BODY_START - 1) begin
                  phase     = PH_FIELD;
                  field_off = 0;
               end
            end
            PH_FIELD: begin
               if (field_off == 0) begin
                  if (body_left == 0 || b != FIELD_DELIM) begin
                     emit(8'h00, KIND_FAIL, 1'b1);
                  end else begin
                     kw_hits   = '0;
                     field_off = 1;
                  end
               end else if (field_off == 1) begin
                  if (b == kw_first) kw_hits[0] = 1'b1;
                  field_off = 2;
               end else if (field_off == 2) begin
                  if (b == kw_second) kw_hits[1] = 1'b1;
                  field_off = 3;
               end else begin
                  field_len = 2 * int'(b);
                  if (b < 2) begin
                     emit(8'h00, KIND_FAIL, 1'b1);
                  end else if (kw_hits == 2'b11) begin
                     if (field_len == DATA_OFFSET) begin
                        emit(8'h00, KIND_FOUND, 1'b1);
                     end else begin
                        phase     = PH_DATA;
                        field_off = DATA_OFFSET;
                     end
                  end else begin
                     // saturate the remaining body length at zero
                     body_left = (body_left > field_len) ? body_left - field_len : 0;
                     if (field_len == DATA_OFFSET) begin
                        field_off = 0;
                     end else begin
                        phase     = PH_SKIP;
                        field_off = DATA_OFFSET;
                     end
                  end
               end
            end
            PH_SKIP: begin
               if (field_off + 1 >= field_len) begin
                  phase     = PH_FIELD;
                  field_off = 0;
               end else begin
                  field_off++;
               end
            end
            PH_DATA: begin
               if (b == 8'h00) begin
                  emit(8'h00, KIND_FOUND, 1'b1);
               end else begin
                  emit(b, KIND_DATA, 1'b0);
                  if (field_off + 1 >= field_len) emit(8'h00, KIND_FOUND, 1'b1);
                  else field_off++;
               end
            end
            default: finished = 1'b1;
         endcase
         if (!finished && (item.last_byte || byte_pos >= IMAGE_LIMIT - 1))
            emit(8'h00, KIND_FAIL, 1'b1);
         if (finished) phase = PH_DONE;
         else byte_pos = (byte_pos + 1) & 32'h0000_FFFF;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 50) $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_beat(vpd_rsp_type got);
         vpd_rsp_type want;
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("beat with nothing pending: byte=%0d kind=%0d end=%0d",
                                      got.out_byte, got.kind, got.run_end));
         end else begin
            want = expected_beats.pop_front();
            if (got.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte got %0d want %0d", got.out_byte,
                                         want.out_byte));
            if (got.kind !== want.kind)
               report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
            if (got.run_end !== want.run_end)
               report_mismatch($sformatf("run_end got %0d want %0d", got.run_end,
                                         want.run_end));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   vpd_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   vpd_rsp_type rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic        pready;

   field_extract_checker scoreboard;
   vpd_req_type image_beats[$];
   int          sent_bytes   = 0;
   int          burst_left   = 0;
   int          quiet_cycles = 0;
   bit          hold_pending = 1'b0;

   vpd_keyword_field_extractor uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Check the result beat before noting the input of the same edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) scoreboard.check_beat(rsp_data);
      if (!reset && req_valid && !req_stall) scoreboard.take_byte(req_data);
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("FAIL");
      $finish;
   end

   // Result side stall pattern, with one long hold-off on request.
   initial begin
      int span;
      int mode;
      rsp_stall <= 1'b0;
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            repeat (HOLD_CYCLES) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 60);
         for (int c = 0; c < span; c++) begin
            @(posedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 2) == 0);
               2: rsp_stall <= (c % 3 == 2);
               default: rsp_stall <= (c % 8 < 5);
            endcase
         end
      end
   end

   task automatic send_beat(input vpd_req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 25);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   task automatic push_byte(input logic [7:0] value, input bit first, input bit last);
      vpd_req_type beat;
      beat.data_byte  = value;
      beat.first_byte = first;
      beat.last_byte  = last;
      image_beats.push_back(beat);
   endtask

   task automatic push_header(input logic [15:0] words, input bit first);
      for (int i = 0; i < BODY_START; i++)
         push_byte((i == HDR_LEN_HIGH_POS) ? words[15:8] :
                   (i == HDR_LEN_LOW_POS) ? words[7:0] : 8'($urandom),
                   first && i == 0, 1'b0);
   endtask

   // zero_at picks the data byte forced to zero; negative keeps all data nonzero
   task automatic push_field(input logic [7:0] delim, input logic [7:0] k1,
                             input logic [7:0] k2, input int len, input int zero_at);
      push_byte(delim, 1'b0, 1'b0);
      push_byte(k1, 1'b0, 1'b0);
      push_byte(k2, 1'b0, 1'b0);
      push_byte(8'(len), 1'b0, 1'b0);
      for (int j = 0; j < 2 * len - int'(DATA_OFFSET); j++)
         push_byte((j == zero_at) ? 8'h00 : 8'($urandom_range(1, 255)), 1'b0, 1'b0);
   endtask

   task automatic finish_image();
      vpd_req_type beat;
      beat = image_beats.pop_back();
      beat.last_byte = 1'b1;
      image_beats.push_back(beat);
   endtask

   task automatic trim_image(input int keep);
      vpd_req_type beat;
      while (image_beats.size() > keep) beat = image_beats.pop_back();
   endtask

   task automatic send_image();
      foreach (image_beats[i]) send_beat(image_beats[i]);
      sent_bytes += image_beats.size();
      image_beats.delete();
   endtask

   task automatic push_random_image();
      int         lens[4];
      int         nfields;
      int         wanted;
      int         words;
      int         pick;
      int         zero_at;
      logic [7:0] k1;
      logic [7:0] k2;
      logic [7:0] delim;
      nfields = $urandom_range(0, 4);
      wanted  = $urandom_range(0, 4);
      words   = 0;
      for (int i = 0; i < nfields; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) lens[i] = $urandom_range(0, 1);
         else if (pick < 92) lens[i] = $urandom_range(2, 8);
         else if (pick < 98) lens[i] = $urandom_range(9, 40);
         else lens[i] = $urandom_range(100, 255);
         words += lens[i];
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) words = $urandom_range(0, words);
      else if (pick == 1) words = $urandom_range(0, 65535);
      if ($urandom_range(0, 9) == 0) begin
         // plain noise
         pick = $urandom_range(4, 40);
         for (int i = 0; i < pick; i++) push_byte(8'($urandom), i == 0, 1'b0);
      end else begin
         push_header(16'(words), $urandom_range(0, 19) != 0);
         for (int i = 0; i < nfields; i++) begin
            k1 = 8'($urandom);
            k2 = 8'($urandom);
            if (i == wanted) begin
               k1 = scoreboard.kw_first;
               k2 = scoreboard.kw_second;
            end else begin
               case ($urandom_range(0, 3))
                  0: ;
                  1: k1 = scoreboard.kw_first;
                  2: k2 = scoreboard.kw_second;
                  default: begin
                     k1 = scoreboard.kw_first;
                     k2 = ~scoreboard.kw_second;
                  end
               endcase
            end
            delim   = ($urandom_range(0, 24) == 0) ? 8'($urandom) : FIELD_DELIM;
            zero_at = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2 * lens[i]) : -1;
            push_field(delim, k1, k2, lens[i], zero_at);
         end
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 1'b0);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0 && image_beats.size() > 1) begin
         trim_image($urandom_range(1, image_beats.size() - 1));
         finish_image();
      end else if (pick != 1) begin
         finish_image();
      end
   endtask

   // Drop valid, drain every pending result, then let the block settle.
   task automatic go_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (scoreboard.expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input vpd_reg_type idx, input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      scoreboard.set_keyword(idx, value);
   endtask

   initial begin
      int         goal;
      logic [7:0] ka;
      logic [7:0] kb;
      scoreboard = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      ka = scoreboard.kw_first;
      kb = scoreboard.kw_second;
      // no start marker after reset; match ends on its last data byte
      push_header(16'd4, 1'b0);
      push_field(FIELD_DELIM, ka, kb, 4, -1);
      finish_image();
      send_image();
      // zero data byte ends the match; the rest of the image is ignored
      push_header(16'd5, 1'b1);
      push_field(FIELD_DELIM, ka, kb, 5, 2);
      finish_image();
      send_image();
      // empty match
      push_header(16'd2, 1'b1);
      push_field(FIELD_DELIM, ka, kb, 2, -1);
      finish_image();
      send_image();
      // zero length on a match is malformed
      push_header(16'd2, 1'b1);
      push_field(FIELD_DELIM, ka, kb, 0, -1);
      finish_image();
      send_image();
      // partial match skipped, then length one
      push_header(16'd6, 1'b1);
      push_field(FIELD_DELIM, ka, ~kb, 3, -1);
      push_field(FIELD_DELIM, ~ka, kb, 1, -1);
      finish_image();
      send_image();
      // missing delimiter
      push_header(16'd8, 1'b1);
      push_byte(8'h00, 1'b0, 1'b0);
      finish_image();
      send_image();
      // empty body
      push_header(16'd0, 1'b1);
      push_field(FIELD_DELIM, ka, kb, 3, -1);
      finish_image();
      send_image();
      // body used up exactly by a skipped field
      push_header(16'd3, 1'b1);
      push_field(FIELD_DELIM, ~ka, kb, 3, -1);
      push_field(FIELD_DELIM, ka, kb, 3, -1);
      finish_image();
      send_image();
      // skipped field longer than the body
      push_header(16'd2, 1'b1);
      push_field(FIELD_DELIM, ~ka, kb, 4, -1);
      push_field(FIELD_DELIM, ka, kb, 2, -1);
      finish_image();
      send_image();
      // image ends inside the matched data
      push_header(16'hFFFF, 1'b1);
      push_field(FIELD_DELIM, ka, ~kb, 2, -1);
      push_field(FIELD_DELIM, ka, kb, 6, -1);
      trim_image(image_beats.size() - 3);
      finish_image();
      send_image();
      // image ends in the header
      push_header(16'd4, 1'b1);
      trim_image(3);
      finish_image();
      send_image();
      // one-byte image
      push_byte(8'hFF, 1'b1, 1'b1);
      // image ends at the end of a skipped field
      push_header(16'd3, 1'b1);
      push_field(FIELD_DELIM, ~ka, ~kb, 3, -1);
      finish_image();
      send_image();
      // restart in the middle of an image; data extremes
      push_header(16'd4, 1'b1);
      push_byte(FIELD_DELIM, 1'b0, 1'b0);
      push_header(16'd3, 1'b1);
      push_byte(FIELD_DELIM, 1'b0, 1'b0);
      push_byte(ka, 1'b0, 1'b0);
      push_byte(kb, 1'b0, 1'b0);
      push_byte(8'd3, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'h01, 1'b0, 1'b0);
      finish_image();
      send_image();
      // image size limit reached inside matched data, then ignored bytes
      push_header(16'd255, 1'b1);
      push_field(FIELD_DELIM, ka, kb, 255, -1);
      trim_image(IMAGE_LIMIT);
      repeat (3) push_byte(8'($urandom), 1'b0, 1'b0);
      send_image();
      // image size limit reached while skipping
      push_header(16'd255, 1'b1);
      push_field(FIELD_DELIM, ~ka, ~kb, 200, -1);
      trim_image(IMAGE_LIMIT);
      repeat (2) push_byte(8'($urandom), 1'b0, 1'b0);
      send_image();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         go_quiet();
         case (p)
            0: begin
               ka = 8'h00;
               kb = 8'hFF;
            end
            1: begin
               ka = 8'hFF;
               kb = 8'h00;
            end
            2: begin
               ka = FIELD_DELIM;
               kb = FIELD_DELIM;
            end
            3: begin
               ka = KEYWORD_FIRST_RESET;
               kb = KEYWORD_SECOND_RESET;
            end
            default: begin
               ka = 8'($urandom);
               kb = 8'($urandom);
            end
         endcase
         csr_write(REG_KEYWORD_FIRST, ka);
         csr_write(REG_KEYWORD_SECOND, kb);
         if (p == 1) hold_pending = 1'b1;
         goal = sent_bytes + BYTES_PER_PHASE;
         while (sent_bytes < goal) begin
            push_random_image();
            send_image();
         end
      end

      go_quiet();
      if (scoreboard.mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
